FILE: hw/rtl/isld_pkg.sv
// Shared types, register codes and constants of the shake and lift detector.
package isld_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int THR_W      = 15;
	localparam int G_W        = 15;
	localparam int WIN_W      = 24;
	localparam int PEAK_N_W   = 4;
	localparam int LIFT_W     = 4;
	localparam int STILL_W    = 8;
	localparam int COOL_W     = 32;
	localparam int KIND_W     = 2;
	localparam int DUR_W      = 10;
	localparam int THR2_W     = 2 * THR_W;
	localparam int HI_W       = G_W + 1;
	localparam int HI2_W      = 2 * HI_W;
	localparam int LO2_W      = 2 * G_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTION_THR  = 3'd0,
		REG_ONE_G       = 3'd1,
		REG_WINDOW      = 3'd2,
		REG_PEAKS_NEED  = 3'd3,
		REG_LIFT_NEED   = 3'd4,
		REG_REARM_NEED  = 3'd5,
		REG_COOLDOWN    = 3'd6
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		EVT_NONE  = 2'd0,
		EVT_SHAKE = 2'd1,
		EVT_LIFT  = 2'd2
	} evt_kind_t;

	localparam logic [DUR_W-1:0] DUR_NONE  = 10'd0;
	localparam logic [DUR_W-1:0] DUR_SHAKE = 10'd1000;
	localparam logic [DUR_W-1:0] DUR_LIFT  = 10'd500;

	localparam logic [LIFT_W-1:0]  LIFT_MAX  = '1;
	localparam logic [STILL_W-1:0] STILL_MAX = '1;

	localparam logic [THR_W-1:0]    RST_THR        = 15'd1229;
	localparam logic [G_W-1:0]      RST_ONE_G      = 15'd4096;
	localparam logic [WIN_W-1:0]    RST_WINDOW     = 24'd1000000;
	localparam logic [PEAK_N_W-1:0] RST_PEAKS_NEED = 4'd2;
	localparam logic [LIFT_W-1:0]   RST_LIFT_NEED  = 4'd5;
	localparam logic [STILL_W-1:0]  RST_REARM_NEED = 8'd50;
	localparam logic [COOL_W-1:0]   RST_COOLDOWN   = 32'd300000000;

	localparam logic [THR2_W-1:0] RST_THR2 = THR2_W'(1229 * 1229);
	localparam logic [HI2_W-1:0]  RST_HI2  = HI2_W'((4096 + 1229) * (4096 + 1229));
	localparam logic [LO2_W-1:0]  RST_LO2  = LO2_W'((4096 - 1229) * (4096 - 1229));

	typedef struct packed {
		logic [WIN_W-1:0]    window;
		logic [PEAK_N_W-1:0] peaks_need;
		logic [LIFT_W-1:0]   lift_need;
		logic [STILL_W-1:0]  rearm_need;
		logic [COOL_W-1:0]   cooldown;
		logic [THR2_W-1:0]   thr2;
		logic [HI2_W-1:0]    hi2;
		logic [LO2_W-1:0]    lo2;
		logic                lo_en;
	} cfg_t;

endpackage

FILE: hw/rtl/isld_cfg.sv
// Configuration registers and the squared thresholds derived from them.
module isld_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [isld_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [isld_pkg::CFG_DATA_W-1:0]    cfg_data,
	output isld_pkg::cfg_t                     cfg
);
	import isld_pkg::*;

	logic [THR_W-1:0]    thr_q;
	logic [G_W-1:0]      one_g_q;
	logic [WIN_W-1:0]    window_q;
	logic [PEAK_N_W-1:0] peaks_need_q;
	logic [LIFT_W-1:0]   lift_need_q;
	logic [STILL_W-1:0]  rearm_need_q;
	logic [COOL_W-1:0]   cooldown_q;
	logic [THR2_W-1:0]   thr2_q;
	logic [HI2_W-1:0]    hi2_q;
	logic [LO2_W-1:0]    lo2_q;
	logic                lo_en_q;
	logic [HI_W-1:0]     hi_c;
	logic [G_W-1:0]      lo_c;

	assign cfg_ready = 1'b1;
	assign hi_c = {1'b0, one_g_q} + {1'b0, thr_q};
	assign lo_c = one_g_q - thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= RST_THR;
			one_g_q      <= RST_ONE_G;
			window_q     <= RST_WINDOW;
			peaks_need_q <= RST_PEAKS_NEED;
			lift_need_q  <= RST_LIFT_NEED;
			rearm_need_q <= RST_REARM_NEED;
			cooldown_q   <= RST_COOLDOWN;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MOTION_THR: thr_q <= THR_W'(cfg_data);
				REG_ONE_G: one_g_q <= G_W'(cfg_data);
				REG_WINDOW: window_q <= WIN_W'(cfg_data);
				REG_PEAKS_NEED: peaks_need_q <= PEAK_N_W'(cfg_data);
				REG_LIFT_NEED: lift_need_q <= LIFT_W'(cfg_data);
				REG_REARM_NEED: rearm_need_q <= STILL_W'(cfg_data);
				REG_COOLDOWN: cooldown_q <= COOL_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// square the thresholds in the config block so the sample path only compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr2_q  <= RST_THR2;
			hi2_q   <= RST_HI2;
			lo2_q   <= RST_LO2;
			lo_en_q <= 1'b1;
		end else begin
			thr2_q  <= thr_q * thr_q;
			hi2_q   <= hi_c * hi_c;
			lo2_q   <= lo_c * lo_c;
			lo_en_q <= one_g_q > thr_q;
		end
	end

	always_comb begin
		cfg.window     = window_q;
		cfg.peaks_need = peaks_need_q;
		cfg.lift_need  = lift_need_q;
		cfg.rearm_need = rearm_need_q;
		cfg.cooldown   = cooldown_q;
		cfg.thr2       = thr2_q;
		cfg.hi2        = hi2_q;
		cfg.lo2        = lo2_q;
		cfg.lo_en      = lo_en_q;
	end

endmodule

FILE: hw/rtl/isld_front.sv
// Sample pipeline: axis deltas, squares, and the moving classification.
module isld_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
	input  logic [TIME_WIDTH-1:0]          time_us,
	input  isld_pkg::cfg_t                 cfg,
	input  logic                           adv,
	output logic                           cls_valid,
	output logic                           cls_moving,
	output logic [TIME_WIDTH-1:0]          cls_time
);
	import isld_pkg::*;

	localparam int DW = SAMPLE_WIDTH + 1;
	localparam int MW = 2 * SAMPLE_WIDTH;
	localparam int QW = 2 * DW;
	localparam int CW = (QW + 2 > HI2_W) ? QW + 2 : HI2_W;

	logic signed [SAMPLE_WIDTH-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic                           prev_vld_q;
	logic                           vld_s1, vld_s2, vld_s3;
	logic                           rdy1, rdy2, rdy3, acc;
	logic signed [SAMPLE_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic signed [DW-1:0]           dx_s1, dy_s1, dz_s1;
	logic [TIME_WIDTH-1:0]          t_s1, t_s2, t_s3;
	logic signed [DW-1:0]           dx_c, dy_c, dz_c;
	logic signed [MW-1:0]           mx2_c, my2_c, mz2_c;
	logic signed [QW-1:0]           dx2_c, dy2_c, dz2_c;
	logic [MW-1:0]                  mx2_s2, my2_s2, mz2_s2;
	logic [QW-1:0]                  dx2_s2, dy2_s2, dz2_s2;
	logic [CW-1:0]                  mag2_c, delta2_c;
	logic                           moving_c, moving_s3;

	assign rdy3     = !vld_s3 || adv;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_stall = !rdy1;
	assign acc      = in_valid && rdy1;

	// first sample sees no change
	assign dx_c = prev_vld_q ? ({accel_x[SAMPLE_WIDTH-1], accel_x} -
		{prev_x_q[SAMPLE_WIDTH-1], prev_x_q}) : '0;
	assign dy_c = prev_vld_q ? ({accel_y[SAMPLE_WIDTH-1], accel_y} -
		{prev_y_q[SAMPLE_WIDTH-1], prev_y_q}) : '0;
	assign dz_c = prev_vld_q ? ({accel_z[SAMPLE_WIDTH-1], accel_z} -
		{prev_z_q[SAMPLE_WIDTH-1], prev_z_q}) : '0;

	assign mx2_c = x_s1 * x_s1;
	assign my2_c = y_s1 * y_s1;
	assign mz2_c = z_s1 * z_s1;
	assign dx2_c = dx_s1 * dx_s1;
	assign dy2_c = dy_s1 * dy_s1;
	assign dz2_c = dz_s1 * dz_s1;

	assign mag2_c   = CW'(mx2_s2) + CW'(my2_s2) + CW'(mz2_s2);
	assign delta2_c = CW'(dx2_s2) + CW'(dy2_s2) + CW'(dz2_s2);
	assign moving_c = (delta2_c > CW'(cfg.thr2)) || (mag2_c > CW'(cfg.hi2)) ||
		(cfg.lo_en && (mag2_c < CW'(cfg.lo2)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			prev_vld_q <= 1'b0;
		end else begin
			if (rdy1)
				vld_s1 <= in_valid;
			if (rdy2)
				vld_s2 <= vld_s1;
			if (rdy3)
				vld_s3 <= vld_s2;
			if (acc)
				prev_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			prev_x_q <= accel_x;
			prev_y_q <= accel_y;
			prev_z_q <= accel_z;
			x_s1     <= accel_x;
			y_s1     <= accel_y;
			z_s1     <= accel_z;
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;
			dz_s1    <= dz_c;
			t_s1     <= time_us;
		end
		if (rdy2) begin
			mx2_s2 <= mx2_c;
			my2_s2 <= my2_c;
			mz2_s2 <= mz2_c;
			dx2_s2 <= dx2_c;
			dy2_s2 <= dy2_c;
			dz2_s2 <= dz2_c;
			t_s2   <= t_s1;
		end
		if (rdy3) begin
			moving_s3 <= moving_c;
			t_s3      <= t_s2;
		end
	end

	assign cls_valid  = vld_s3;
	assign cls_moving = moving_s3;
	assign cls_time   = t_s3;

endmodule

FILE: hw/rtl/isld_track.sv
// Event state: arming, cooldown, peak ring, lift count and the result register.
module isld_track #(
	parameter int PEAK_RING_DEPTH = 8,
	parameter int TIME_WIDTH      = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  isld_pkg::cfg_t                      cfg,
	input  logic                                cls_valid,
	input  logic                                cls_moving,
	input  logic [TIME_WIDTH-1:0]               cls_time,
	output logic                                adv,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [isld_pkg::KIND_W-1:0]         event_kind,
	output logic [isld_pkg::DUR_W-1:0]          event_duration_ms,
	output logic                                is_moving
);
	import isld_pkg::*;

	localparam int IW = $clog2(PEAK_RING_DEPTH);
	localparam int PW = $clog2(PEAK_RING_DEPTH + 1);
	localparam int NW = (PW > PEAK_N_W) ? PW : PEAK_N_W;

	logic [TIME_WIDTH-1:0]      peak_time_q [PEAK_RING_DEPTH];
	logic [PEAK_RING_DEPTH-1:0] peak_vld_q, peak_vld_n, hit;
	logic [IW-1:0]              widx_q, widx_n, widx_inc;
	logic [STILL_W-1:0]         still_q, still_n, still_inc;
	logic [LIFT_W-1:0]          lift_q, lift_n, lift_inc;
	logic                       armed_q, armed_n;
	logic                       seen_q, seen_n;
	logic [TIME_WIDTH-1:0]      last_q, last_n, cool_el;
	logic                       cool, shake, ring_wr, take;
	logic [PW-1:0]              peak_cnt;
	evt_kind_t                  kind_c, kind_q;
	logic [DUR_W-1:0]           dur_c, dur_q;
	logic                       out_valid_q, moving_q;

	assign adv  = !out_valid_q || !out_stall;
	assign take = cls_valid && adv;

	always_comb begin
		logic [TIME_WIDTH-1:0] el;
		el  = '0;
		hit = '0;
		for (int i = 0; i < PEAK_RING_DEPTH; i++) begin
			el = (cls_time >= peak_time_q[i]) ? cls_time - peak_time_q[i] : '0;
			if (IW'(i) == widx_q)
				hit[i] = cfg.window != '0;
			else
				hit[i] = peak_vld_q[i] && (el < TIME_WIDTH'(cfg.window));
		end
	end

	assign peak_cnt  = PW'($countones(hit));
	assign shake     = NW'(peak_cnt) >= NW'(cfg.peaks_need);
	assign cool_el   = (cls_time >= last_q) ? cls_time - last_q : '0;
	assign cool      = seen_q && (cool_el < TIME_WIDTH'(cfg.cooldown));
	assign widx_inc  = (widx_q == IW'(PEAK_RING_DEPTH - 1)) ? '0 : widx_q + 1'b1;
	assign still_inc = (still_q == STILL_MAX) ? still_q : still_q + 1'b1;
	assign lift_inc  = (lift_q == LIFT_MAX) ? lift_q : lift_q + 1'b1;

	always_comb begin
		armed_n    = armed_q;
		still_n    = still_q;
		lift_n     = lift_q;
		seen_n     = seen_q;
		last_n     = last_q;
		peak_vld_n = peak_vld_q;
		widx_n     = widx_q;
		ring_wr    = 1'b0;
		kind_c     = EVT_NONE;
		dur_c      = DUR_NONE;
		if (!cls_moving) begin
			still_n = still_inc;
			if (still_inc >= cfg.rearm_need)
				armed_n = 1'b1;
			lift_n     = '0;
			peak_vld_n = '0;
		end else begin
			still_n = '0;
			if (armed_q && !cool) begin
				ring_wr = 1'b1;
				for (int i = 0; i < PEAK_RING_DEPTH; i++)
					if (IW'(i) == widx_q)
						peak_vld_n[i] = 1'b1;
				widx_n = widx_inc;
				if (shake) begin
					armed_n    = 1'b0;
					lift_n     = '0;
					last_n     = cls_time;
					seen_n     = 1'b1;
					peak_vld_n = '0;
					kind_c     = EVT_SHAKE;
					dur_c      = DUR_SHAKE;
				end else begin
					lift_n = lift_inc;
					if (lift_inc >= cfg.lift_need) begin
						armed_n = 1'b0;
						lift_n  = '0;
						last_n  = cls_time;
						seen_n  = 1'b1;
						kind_c  = EVT_LIFT;
						dur_c   = DUR_LIFT;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b1;
			still_q     <= '0;
			lift_q      <= '0;
			seen_q      <= 1'b0;
			last_q      <= '0;
			peak_vld_q  <= '0;
			widx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				armed_q    <= armed_n;
				still_q    <= still_n;
				lift_q     <= lift_n;
				seen_q     <= seen_n;
				last_q     <= last_n;
				peak_vld_q <= peak_vld_n;
				widx_q     <= widx_n;
			end
			if (adv)
				out_valid_q <= cls_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q   <= kind_c;
			dur_q    <= dur_c;
			moving_q <= cls_moving;
			if (ring_wr)
				peak_time_q[widx_q] <= cls_time;
		end
	end

	assign out_valid         = out_valid_q;
	assign event_kind        = kind_q;
	assign event_duration_ms = dur_q;
	assign is_moving         = moving_q;

endmodule

FILE: hw/rtl/imu_shake_lift_detector_top.sv
// Top level of the accelerometer shake and lift detector.
//
// Input channel: in_valid/in_stall with accel_x, accel_y, accel_z and time_us.
// A transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with event_kind, event_duration_ms and
// is_moving; exactly one result per input sample, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no sample is in flight.
// An input transfer reaches out_valid through four registers: input register,
// squaring stage, sum-and-compare stage, event state update into the result
// register. One sample per cycle is accepted while in_stall is low;
// the event state loop closes within the last stage.
// When the receiver stalls, held results stay put and earlier stages keep
// filling until every stage holds a sample; only then is in_stall raised.
// Reset loads the register defaults, arms the detector, empties the peak ring
// and clears the cooldown history.
module imu_shake_lift_detector_top #(
	parameter int PEAK_RING_DEPTH = 8,
	parameter int SAMPLE_WIDTH    = 16,
	parameter int TIME_WIDTH      = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]     accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0]     accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0]     accel_z,
	input  logic [TIME_WIDTH-1:0]              time_us,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [isld_pkg::KIND_W-1:0]        event_kind,
	output logic [isld_pkg::DUR_W-1:0]         event_duration_ms,
	output logic                               is_moving,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [isld_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [isld_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import isld_pkg::*;

	cfg_t                  cfg;
	logic                  adv;
	logic                  cls_valid;
	logic                  cls_moving;
	logic [TIME_WIDTH-1:0] cls_time;

	isld_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	isld_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.time_us    (time_us),
		.cfg        (cfg),
		.adv        (adv),
		.cls_valid  (cls_valid),
		.cls_moving (cls_moving),
		.cls_time   (cls_time)
	);

	isld_track #(
		.PEAK_RING_DEPTH (PEAK_RING_DEPTH),
		.TIME_WIDTH      (TIME_WIDTH)
	) u_track (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cls_valid         (cls_valid),
		.cls_moving        (cls_moving),
		.cls_time          (cls_time),
		.adv               (adv),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.event_kind        (event_kind),
		.event_duration_ms (event_duration_ms),
		.is_moving         (is_moving)
	);

`ifndef NO_ASSERTIONS
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output side is free");

	a_event_needs_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind != EVT_NONE)) |-> is_moving)
		else $error("event reported on a still sample");

	a_idle_duration: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind == EVT_NONE)) |-> (event_duration_ms == DUR_NONE))
		else $error("duration set without an event");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the shake and lift detector: sample traffic against a predictor.
module testbench;
	import isld_pkg::*;

	localparam int AXIS_W      = 16;
	localparam int TS_W        = 48;
	localparam int RING_N      = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 23;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [TS_W-1:0] TS_MAX = '1;

	typedef struct {
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
		logic signed [AXIS_W-1:0] az;
		logic [TS_W-1:0]          ts;
	} sample_t;

	typedef struct {
		evt_kind_t        kind;
		logic [DUR_W-1:0] dur;
		logic             moving;
	} verdict_t;

	typedef struct {
		logic [THR_W-1:0]    thr;
		logic [G_W-1:0]      one_g;
		logic [WIN_W-1:0]    window;
		logic [PEAK_N_W-1:0] peaks_need;
		logic [LIFT_W-1:0]   lift_need;
		logic [STILL_W-1:0]  rearm_need;
		logic [COOL_W-1:0]   cooldown;
	} settings_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [AXIS_W-1:0] accel_x = '0;
	logic signed [AXIS_W-1:0] accel_y = '0;
	logic signed [AXIS_W-1:0] accel_z = '0;
	logic [TS_W-1:0]          time_us = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [KIND_W-1:0]        event_kind;
	logic [DUR_W-1:0]         event_duration_ms;
	logic                     is_moving;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	imu_shake_lift_detector_top i_dut (.*);

	always #10 clk = ~clk;

	settings_t       cur_cfg;
	longint          prev_axis [3];
	bit              prev_seen;
	int unsigned     lift_cnt;
	int unsigned     still_cnt;
	bit              armed;
	longint unsigned peak_ts [RING_N];
	bit              peak_live [RING_N];
	int unsigned     peak_wr;
	longint unsigned last_evt_ts;
	bit              evt_seen;

	sample_t         pending_samples [$];
	verdict_t        expected_verdicts [$];
	sample_t         on_bus;
	bit              steady = 1'b0;
	longint unsigned gen_ts;
	int unsigned     n_cycles = 0;
	int unsigned     n_errors = 0;
	int unsigned     n_samples = 0;
	int unsigned     n_settings = 0;
	int unsigned     n_shakes = 0;
	int unsigned     n_lifts = 0;
	int unsigned     n_moving = 0;

	function automatic void empty_ring();
		foreach (peak_live[i]) begin
			peak_live[i] = 1'b0;
			peak_ts[i] = 0;
		end
	endfunction

	function automatic longint unsigned since(longint unsigned now, longint unsigned then);
		return (now >= then) ? now - then : 0;
	endfunction

	function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_MOTION_THR: cur_cfg.thr = val[THR_W-1:0];
			REG_ONE_G:      cur_cfg.one_g = val[G_W-1:0];
			REG_WINDOW:     cur_cfg.window = val[WIN_W-1:0];
			REG_PEAKS_NEED: cur_cfg.peaks_need = val[PEAK_N_W-1:0];
			REG_LIFT_NEED:  cur_cfg.lift_need = val[LIFT_W-1:0];
			REG_REARM_NEED: cur_cfg.rearm_need = val[STILL_W-1:0];
			REG_COOLDOWN:   cur_cfg.cooldown = val[COOL_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic verdict_t track_sample(sample_t s);
		longint          sv [3];
		longint          d;
		longint unsigned now, t, g, thr2, mag2, delta2, hi, lo;
		int unsigned     peaks;
		bit              moving;
		verdict_t        r;
		sv[0] = s.ax;
		sv[1] = s.ay;
		sv[2] = s.az;
		now = s.ts;
		t = cur_cfg.thr;
		g = cur_cfg.one_g;
		thr2 = t * t;
		mag2 = 0;
		delta2 = 0;
		for (int i = 0; i < 3; i++) begin
			mag2 += sv[i] * sv[i];
			if (prev_seen) begin
				d = sv[i] - prev_axis[i];
				delta2 += d * d;
			end
		end
		prev_axis = sv;
		prev_seen = 1'b1;

		hi = g + t;
		moving = (delta2 > thr2) || (mag2 > hi * hi);
		if (g > t) begin
			lo = g - t;
			if (mag2 < lo * lo)
				moving = 1'b1;
		end

		r.kind = EVT_NONE;
		r.dur = DUR_NONE;
		r.moving = moving;
		if (!moving) begin
			if (still_cnt < STILL_MAX)
				still_cnt++;
			if (still_cnt >= cur_cfg.rearm_need)
				armed = 1'b1;
			lift_cnt = 0;
			empty_ring();
		end else begin
			still_cnt = 0;
			if (armed && !(evt_seen && since(now, last_evt_ts) < cur_cfg.cooldown)) begin
				peak_ts[peak_wr] = now;
				peak_live[peak_wr] = 1'b1;
				peak_wr = (peak_wr + 1) % RING_N;
				peaks = 0;
				for (int i = 0; i < RING_N; i++)
					if (peak_live[i] && since(now, peak_ts[i]) < cur_cfg.window)
						peaks++;
				if (peaks >= cur_cfg.peaks_need) begin
					armed = 1'b0;
					lift_cnt = 0;
					last_evt_ts = now;
					evt_seen = 1'b1;
					empty_ring();
					r.kind = EVT_SHAKE;
					r.dur = DUR_SHAKE;
				end else begin
					if (lift_cnt < LIFT_MAX)
						lift_cnt++;
					if (lift_cnt >= cur_cfg.lift_need) begin
						armed = 1'b0;
						lift_cnt = 0;
						last_evt_ts = now;
						evt_seen = 1'b1;
						r.kind = EVT_LIFT;
						r.dur = DUR_LIFT;
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_verdicts.push_back(track_sample(on_bus));
				n_samples++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() > 0 &&
						(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					on_bus = pending_samples.pop_front();
					accel_x <= on_bus.ax;
					accel_y <= on_bus.ay;
					accel_z <= on_bus.az;
					time_us <= on_bus.ts;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected transfer: kind %0d dur %0d moving %0b",
					$time, event_kind, event_duration_ms, is_moving);
				n_errors++;
			end else begin
				want = expected_verdicts.pop_front();
				if (event_kind !== want.kind) begin
					$display("%0t: event_kind expected %0d, actual %0d",
						$time, want.kind, event_kind);
					n_errors++;
				end
				if (event_duration_ms !== want.dur) begin
					$display("%0t: event_duration_ms expected %0d, actual %0d",
						$time, want.dur, event_duration_ms);
					n_errors++;
				end
				if (is_moving !== want.moving) begin
					$display("%0t: is_moving expected %0b, actual %0b",
						$time, want.moving, is_moving);
					n_errors++;
				end
				if (want.kind == EVT_SHAKE)
					n_shakes++;
				if (want.kind == EVT_LIFT)
					n_lifts++;
				if (want.moving)
					n_moving++;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				n_cycles, expected_verdicts.size());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic settle();
		while (pending_samples.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, val);
	endtask

	task automatic program_all(settings_t c, bit wide);
		logic [CFG_DATA_W-1:0] junk;
		junk = wide ? $urandom : '0;
		write_reg(REG_MOTION_THR, (junk << THR_W) | c.thr);
		write_reg(REG_ONE_G, (junk << G_W) | c.one_g);
		write_reg(REG_WINDOW, (junk << WIN_W) | c.window);
		write_reg(REG_PEAKS_NEED, (junk << PEAK_N_W) | c.peaks_need);
		write_reg(REG_LIFT_NEED, (junk << LIFT_W) | c.lift_need);
		write_reg(REG_REARM_NEED, (junk << STILL_W) | c.rearm_need);
		write_reg(REG_COOLDOWN, c.cooldown);
		if (wide)
			write_reg(REG_SPARE, junk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic void queue_sample(int x, int y, int z, longint unsigned ts);
		sample_t s;
		s.ax = AXIS_W'(x);
		s.ay = AXIS_W'(y);
		s.az = AXIS_W'(z);
		s.ts = TS_W'(ts);
		pending_samples.push_back(s);
	endfunction

	function automatic logic [TS_W-1:0] next_ts();
		int unsigned roll;
		int unsigned back;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			gen_ts += $urandom_range(0, cur_cfg.window / 2 + 1);
		end else if (roll < 85) begin
			gen_ts += $urandom_range(0, cur_cfg.cooldown / 4 + 2);
		end else if (roll >= 95) begin
			back = $urandom_range(1, 1000);
			if (gen_ts >= back)
				gen_ts -= back;
		end
		gen_ts &= TS_MAX;
		return TS_W'(gen_ts);
	endfunction

	function automatic sample_t still_sample(int axis, bit neg);
		sample_t s;
		int      j;
		int      g;
		int      v;
		j = cur_cfg.thr / 8;
		g = int'(cur_cfg.one_g) - int'($urandom_range(0, j));
		v = neg ? -g : g;
		s.ax = AXIS_W'(int'($urandom_range(0, 2 * j)) - j);
		s.ay = AXIS_W'(int'($urandom_range(0, 2 * j)) - j);
		s.az = AXIS_W'(int'($urandom_range(0, 2 * j)) - j);
		case (axis)
			0: s.ax = AXIS_W'(v);
			1: s.ay = AXIS_W'(v);
			default: s.az = AXIS_W'(v);
		endcase
		s.ts = next_ts();
		return s;
	endfunction

	function automatic sample_t moving_sample();
		sample_t s;
		s.ax = AXIS_W'($urandom);
		s.ay = AXIS_W'($urandom);
		s.az = AXIS_W'($urandom);
		s.ts = next_ts();
		return s;
	endfunction

	function automatic void queue_bursts(int unsigned n);
		int unsigned added;
		int unsigned run;
		int          axis;
		bit          neg;
		sample_t     s;
		added = 0;
		while (added < n) begin
			if ($urandom_range(0, 99) < 10) begin
				s = moving_sample();
				s.ts = {16'($urandom), 32'($urandom)};
				pending_samples.push_back(s);
				added++;
			end else begin
				axis = $urandom_range(0, 2);
				neg = 1'($urandom_range(0, 1));
				run = $urandom_range(1, cur_cfg.rearm_need + 4);
				repeat (run) pending_samples.push_back(still_sample(axis, neg));
				added += run;
				run = $urandom_range(1, 12);
				repeat (run) pending_samples.push_back(moving_sample());
				added += run;
			end
		end
	endfunction

	function automatic settings_t pick_settings();
		settings_t c;
		c.one_g = G_W'($urandom_range(1024, 8192));
		c.thr = ($urandom_range(0, 99) < 10) ? THR_W'($urandom_range(0, 32767))
			: THR_W'($urandom_range(c.one_g / 16, c.one_g / 3));
		c.window = WIN_W'($urandom_range(1, 2000));
		c.peaks_need = ($urandom_range(0, 99) < 80) ? PEAK_N_W'($urandom_range(1, 4))
			: PEAK_N_W'($urandom_range(0, 15));
		c.lift_need = LIFT_W'($urandom_range(0, 15));
		c.rearm_need = STILL_W'($urandom_range(0, 10));
		c.cooldown = COOL_W'($urandom_range(0, 5000));
		return c;
	endfunction

	initial begin
		settings_t c;
		cur_cfg = '{thr: RST_THR, one_g: RST_ONE_G, window: RST_WINDOW,
			peaks_need: RST_PEAKS_NEED, lift_need: RST_LIFT_NEED,
			rearm_need: RST_REARM_NEED, cooldown: RST_COOLDOWN};
		prev_axis = '{0, 0, 0};
		prev_seen = 1'b0;
		lift_cnt = 0;
		still_cnt = 0;
		armed = 1'b1;
		empty_ring();
		peak_wr = 0;
		last_evt_ts = 0;
		evt_seen = 1'b0;
		gen_ts = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		queue_sample(0, 0, 0, 0);
		queue_sample(-32768, -32768, -32768, 0);
		queue_sample(32767, 32767, 32767, 1);
		queue_sample(0, 0, 4096, 2);
		queue_sample(0, 0, 5325, 3);
		queue_sample(0, 0, 2867, 4);
		queue_sample(0, 0, 2867, 5);
		queue_sample(0, 0, 2866, 6);
		queue_sample(-1, -1, -1, 2);
		queue_sample(0, 0, -4096, TS_MAX);
		settle();

		c = '{thr: '0, one_g: 15'd1, window: 24'd1, peaks_need: '0, lift_need: '0,
			rearm_need: '0, cooldown: '0};
		program_all(c, 1'b0);
		@(negedge clk);
		queue_sample(0, 0, 1, 100);
		queue_sample(0, 0, 1, 100);
		queue_sample(0, 0, -1, 101);
		queue_sample(0, 0, -1, 101);
		queue_sample(0, -1, 0, 102);
		settle();

		c = '{thr: '1, one_g: '1, window: '1, peaks_need: 4'd8, lift_need: '1,
			rearm_need: '1, cooldown: '1};
		program_all(c, 1'b0);
		@(negedge clk);
		for (int i = 0; i < 9; i++)
			queue_sample((i % 2) ? -32768 : 32767, (i % 2) ? -32768 : 32767,
				(i % 2) ? -32768 : 32767, 1000 + i);
		settle();

		c = '{thr: 15'd100, one_g: 15'd4096, window: '1, peaks_need: 4'd9, lift_need: 4'd1,
			rearm_need: 8'd1, cooldown: '0};
		program_all(c, 1'b1);
		@(negedge clk);
		queue_sample(0, 0, 4096, 5000);
		queue_sample(0, 0, -4096, 5001);
		queue_sample(0, 0, -4096, 5002);
		queue_sample(4096, 0, 0, 5003);

		for (int p = 0; p < 12; p++) begin
			c = pick_settings();
			if (p == 5)
				c.rearm_need = STILL_MAX;
			settle();
			program_all(c, 1'($urandom_range(0, 1)));
			@(negedge clk);
			steady = (p == 3);
			gen_ts = (p == 7) ? TS_MAX - 3000 : $urandom;
			if (p == 5)
				repeat (270) pending_samples.push_back(still_sample(2, 1'b0));
			queue_bursts(130);
		end
		settle();

		$display("Checked %0d samples over %0d register settings, %0d of them moving.",
			n_samples, n_settings, n_moving);
		$display("Reported events: %0d shakes, %0d lifts.", n_shakes, n_lifts);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
